### src/cpr_pkg.sv
package cpr_pkg;

   localparam int PAL_AW    = 13;
   localparam int PAL_DEPTH = 2 ** PAL_AW;
   localparam int COLOR_W   = 24;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_PIXEL = 2'd2;
   localparam logic [1:0] CMD_POP   = 2'd3;

   localparam logic [2:0] REG_ADDR_LO   = 3'd0;
   localparam logic [2:0] REG_ADDR_HI   = 3'd1;
   localparam logic [2:0] REG_PALETTE   = 3'd2;
   localparam logic [2:0] REG_COMMAND   = 3'd3;
   localparam logic [2:0] REG_STATUS    = 3'd4;
   localparam logic [2:0] REG_COLOR_BUF = 3'd5;
   localparam logic [2:0] REG_REVISION  = 3'd6;
   localparam logic [2:0] REG_READ_INIT = 3'd7;

   localparam logic [1:0] COMP_RED   = 2'd0;
   localparam logic [1:0] COMP_GREEN = 2'd1;
   localparam logic [1:0] COMP_BLUE  = 2'd2;

   localparam logic [1:0] MODE_INDEX    = 2'd0;
   localparam logic [4:0] RGB_BANK_BASE = 5'h1C;

   localparam logic CSR_BOARD_REV = 1'b0;
   localparam logic CSR_CHIP_REV  = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  reg_select;
      logic [7:0]  write_data;
      logic [23:0] pixel_in;
      logic [1:0]  pixel_mode;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [23:0] pixel_color;
      logic        pop_valid;
      logic [12:0] pop_index;
      logic [23:0] pop_color;
   } rsp_type;

   typedef struct packed {
      logic [PAL_AW-1:0]  index;
      logic [COLOR_W-1:0] color;
   } fifo_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic half;
      logic almost;
   } fifo_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GREEN,
      ST_BLUE,
      ST_DONE
   } state_type;

endpackage

### src/color_palette_ramdac_port.sv
// Colour-map port with an 8K x 24-bit palette behind a byte-wide register bus, a pixel
// lookup path and a write FIFO of completed palette writes. After reset the palette is
// swept to zero one entry per cycle; no request is taken during the sweep (configuration
// writes still land). Register, FIFO pop and colour-index requests go from IDLE to DONE;
// RGB lookups also pass through GREEN and BLUE, as their three palette reads share the
// palette's single synchronous read port. A finished response waits in an output
// register, and a request completes only once that register is free or being emptied.
module color_palette_ramdac_port import cpr_pkg::*; #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [3:0] csr_wdata
);

   logic [COLOR_W-1:0] pal_ram [PAL_DEPTH];
   logic [COLOR_W-1:0] pal_rd_ff;
   logic               pal_rd_en;
   logic [PAL_AW-1:0]  pal_raddr;
   logic               pal_we;
   logic [PAL_AW-1:0]  pal_waddr;
   logic [COLOR_W-1:0] pal_wdata;

   state_type          state_ff, state_in;
   logic [PAL_AW-1:0]  clr_addr_ff, clr_addr_in;
   req_type            req_ff, req_in;
   logic               pop_hit_ff, pop_hit_in;
   logic [PAL_AW-1:0]  addr_ff, addr_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [COLOR_W-1:0] holding_ff, holding_in;
   logic [4:0]         cmd_bits_ff, cmd_bits_in;
   logic [3:0]         board_rev_ff, board_rev_in;
   logic [2:0]         chip_rev_ff, chip_rev_in;
   logic [7:0]         red_ff, red_in;
   logic [7:0]         green_ff, green_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               slot_free;
   logic               commit;
   logic               pal_write_hit;
   logic [COLOR_W-1:0] merged;
   logic [7:0]         pal_byte;
   logic [7:0]         status_byte;
   fifo_entry_type     fifo_push_data;
   fifo_entry_type     fifo_pop_data;
   fifo_status_type    fifo_status;
   logic               fifo_push_en;
   logic               fifo_pop_en;

   function automatic logic [PAL_AW-1:0] rgb_addr(logic [1:0] mode, logic [7:0] comp);
      logic [4:0] bank;
      bank = RGB_BANK_BASE + {3'b000, mode};
      return {bank, comp};
   endfunction

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign commit      = (state_ff == ST_DONE) && slot_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign pal_write_hit = (req_ff.cmd == CMD_WRITE) && (req_ff.reg_select == REG_PALETTE);

   always_comb begin
      case (cnt_ff)
         COMP_RED: begin
            merged   = {req_ff.write_data, pal_rd_ff[15:0]};
            pal_byte = pal_rd_ff[23:16];
         end
         COMP_GREEN: begin
            merged   = {pal_rd_ff[23:16], req_ff.write_data, pal_rd_ff[7:0]};
            pal_byte = pal_rd_ff[15:8];
         end
         default: begin
            merged   = {pal_rd_ff[23:8], req_ff.write_data};
            pal_byte = pal_rd_ff[7:0];
         end
      endcase
   end

   assign status_byte = {3'b000, cmd_bits_ff[4] ? fifo_status.almost : fifo_status.half,
                         fifo_status.full, fifo_status.empty, cnt_ff};

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            if (req_payload.cmd == CMD_PIXEL) begin
               pal_raddr = (req_payload.pixel_mode == MODE_INDEX)
                  ? req_payload.pixel_in[PAL_AW-1:0]
                  : rgb_addr(req_payload.pixel_mode, req_payload.pixel_in[23:16]);
            end else begin
               pal_raddr = addr_ff;
            end
         end
         ST_GREEN: pal_raddr = rgb_addr(req_ff.pixel_mode, req_ff.pixel_in[15:8]);
         ST_BLUE:  pal_raddr = rgb_addr(req_ff.pixel_mode, req_ff.pixel_in[7:0]);
         default:  pal_raddr = addr_ff;
      endcase
   end

   assign pal_rd_en = accept || (state_ff == ST_GREEN) || (state_ff == ST_BLUE);
   assign pal_we    = (state_ff == ST_CLEAR) || (commit && pal_write_hit);
   assign pal_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
   assign pal_wdata = (state_ff == ST_CLEAR) ? '0 : merged;

   assign fifo_push_en         = commit && pal_write_hit && (cnt_ff != COMP_RED)
                                 && (cnt_ff != COMP_GREEN);
   assign fifo_push_data.index = addr_ff;
   assign fifo_push_data.color = merged;
   assign fifo_pop_en          = accept && (req_payload.cmd == CMD_POP);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      req_in       = req_ff;
      pop_hit_in   = pop_hit_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      holding_in   = holding_ff;
      cmd_bits_in  = cmd_bits_ff;
      board_rev_in = board_rev_ff;
      chip_rev_in  = chip_rev_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_BOARD_REV: board_rev_in = csr_wdata;
            default:       chip_rev_in  = csr_wdata[2:0];
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_payload;
               pop_hit_in = (req_payload.cmd == CMD_POP) && !fifo_status.empty;
               if ((req_payload.cmd == CMD_PIXEL) && (req_payload.pixel_mode != MODE_INDEX)) begin
                  state_in = ST_GREEN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_GREEN: begin
            red_in   = pal_rd_ff[7:0];
            state_in = ST_BLUE;
         end
         ST_BLUE: begin
            green_in = pal_rd_ff[7:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               case (req_ff.cmd)
                  CMD_READ: begin
                     case (req_ff.reg_select)
                        REG_ADDR_LO: rsp_in.read_data = addr_ff[7:0];
                        REG_ADDR_HI: rsp_in.read_data = {3'b000, addr_ff[12:8]};
                        REG_PALETTE: begin
                           rsp_in.read_data = pal_byte;
                           holding_in       = pal_rd_ff;
                           case (cnt_ff)
                              COMP_RED:   cnt_in = COMP_GREEN;
                              COMP_GREEN: cnt_in = COMP_BLUE;
                              default: begin
                                 cnt_in  = COMP_RED;
                                 addr_in = addr_ff + 1'b1;
                              end
                           endcase
                        end
                        REG_COMMAND: rsp_in.read_data = {3'b000, cmd_bits_ff};
                        REG_STATUS:  rsp_in.read_data = status_byte;
                        REG_COLOR_BUF: begin
                           case (cnt_ff)
                              COMP_RED: begin
                                 rsp_in.read_data = holding_ff[23:16];
                                 cnt_in           = COMP_GREEN;
                              end
                              COMP_GREEN: begin
                                 rsp_in.read_data = holding_ff[15:8];
                                 cnt_in           = COMP_BLUE;
                              end
                              default: rsp_in.read_data = '0;
                           endcase
                        end
                        REG_REVISION: rsp_in.read_data = {board_rev_ff, 1'b0, chip_rev_ff};
                        default:      rsp_in.read_data = '0;
                     endcase
                  end
                  CMD_WRITE: begin
                     case (req_ff.reg_select)
                        REG_ADDR_LO: begin
                           addr_in = {addr_ff[12:8], req_ff.write_data};
                           cnt_in  = COMP_RED;
                        end
                        REG_ADDR_HI: begin
                           addr_in = {req_ff.write_data[4:0], addr_ff[7:0]};
                           cnt_in  = COMP_RED;
                        end
                        REG_PALETTE: begin
                           case (cnt_ff)
                              COMP_RED:   cnt_in = COMP_GREEN;
                              COMP_GREEN: cnt_in = COMP_BLUE;
                              default: begin
                                 cnt_in  = COMP_RED;
                                 addr_in = addr_ff + 1'b1;
                              end
                           endcase
                        end
                        REG_COMMAND: cmd_bits_in = req_ff.write_data[4:0];
                        default: ;
                     endcase
                  end
                  CMD_PIXEL: begin
                     if (req_ff.pixel_mode == MODE_INDEX) begin
                        rsp_in.pixel_color = pal_rd_ff;
                     end else begin
                        rsp_in.pixel_color = {red_ff, green_ff, pal_rd_ff[7:0]};
                     end
                  end
                  default: begin
                     if (pop_hit_ff) begin
                        rsp_in.pop_valid = 1'b1;
                        rsp_in.pop_index = fifo_pop_data.index;
                        rsp_in.pop_color = fifo_pop_data.color;
                     end
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pop_hit_ff   <= 1'b0;
         addr_ff      <= '0;
         cnt_ff       <= COMP_RED;
         holding_ff   <= '0;
         cmd_bits_ff  <= '0;
         board_rev_ff <= '0;
         chip_rev_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pop_hit_ff   <= pop_hit_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         holding_ff   <= holding_in;
         cmd_bits_ff  <= cmd_bits_in;
         board_rev_ff <= board_rev_in;
         chip_rev_ff  <= chip_rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_ram[pal_waddr] <= pal_wdata;
      end
      if (pal_rd_en) begin
         pal_rd_ff <= pal_ram[pal_raddr];
      end
   end

   cpr_wfifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_wfifo (
      .clock    (clock),
      .reset    (reset),
      .push_en  (fifo_push_en),
      .push_data(fifo_push_data),
      .pop_en   (fifo_pop_en),
      .pop_data (fifo_pop_data),
      .status   (fifo_status)
   );

   a_cnt_legal: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == COMP_RED || cnt_ff == COMP_GREEN || cnt_ff == COMP_BLUE)
      else $error("component counter out of range");

   a_fifo_flags: assert property (@(posedge clock) disable iff (reset)
      !(fifo_status.empty && fifo_status.full))
      else $error("write FIFO empty and full together");

   a_rgb_timing: assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.cmd == CMD_PIXEL) && (req_payload.pixel_mode != MODE_INDEX)
      |-> ##3 (state_ff == ST_DONE))
      else $error("RGB lookup did not reach completion after three reads");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff && !fifo_push_en)
      else $error("activity during palette clearing sweep");

endmodule

### src/cpr_wfifo.sv
module cpr_wfifo import cpr_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_en,
   input  fifo_entry_type  push_data,
   input  logic            pop_en,
   output fifo_entry_type  pop_data,
   output fifo_status_type status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
   localparam logic [CW-1:0] HALF_CNT = CW'(DEPTH / 2);
   localparam logic [CW-1:0] ALMOST_CNT = CW'(DEPTH - 8);

   fifo_entry_type ram [DEPTH];
   fifo_entry_type rd_ff;

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign do_push = push_en && (count_ff != FULL_CNT);
   assign do_pop  = pop_en && (count_ff != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (do_pop) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ram[head_ff] <= push_data;
      end
      if (do_pop) begin
         rd_ff <= ram[tail_ff];
      end
   end

   assign pop_data      = rd_ff;
   assign status.empty  = (count_ff == '0);
   assign status.full   = (count_ff == FULL_CNT);
   assign status.half   = (count_ff >= HALF_CNT);
   assign status.almost = (count_ff >= ALMOST_CNT);

endmodule

### dv/color_palette_ramdac_port_test.sv
`timescale 1ns / 100ps

module color_palette_ramdac_port_test;
   import cpr_pkg::*;

   localparam int FIFO_DEPTH  = 32;
   localparam int QUIET_LIMIT = 50000;
   localparam int PRINT_LIMIT = 100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic       csr_write_en = 1'b0;
   logic       csr_index = CSR_BOARD_REV;
   logic [3:0] csr_wdata = '0;

   bit [23:0]      palette_mirror [PAL_DEPTH];
   fifo_entry_type write_fifo_mirror [$];
   logic [12:0]    pal_addr = '0;
   logic [1:0]     comp = COMP_RED;
   logic [23:0]    held_color = '0;
   logic [4:0]     cmd_bits = '0;
   logic [3:0]     board_rev = '0;
   logic [2:0]     chip_rev = '0;

   rsp_type responses_due [$];
   int      requests_counted = 0;
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_off_cycles = 0;
   int      quiet_cycles = 0;

   color_palette_ramdac_port #(.QUEUE_DEPTH(FIFO_DEPTH)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic rsp_type port_response(req_type r);
      rsp_type        rsp;
      logic [23:0]    entry;
      logic [4:0]     bank;
      fifo_entry_type popped;
      int             thr;
      rsp = '0;
      entry = palette_mirror[pal_addr];
      case (r.cmd)
         CMD_READ: begin
            case (r.reg_select)
               REG_ADDR_LO: rsp.read_data = pal_addr[7:0];
               REG_ADDR_HI: rsp.read_data = {3'b000, pal_addr[12:8]};
               REG_PALETTE: begin
                  held_color = entry;
                  if (comp == COMP_RED) begin
                     rsp.read_data = entry[23:16];
                     comp = COMP_GREEN;
                  end else if (comp == COMP_GREEN) begin
                     rsp.read_data = entry[15:8];
                     comp = COMP_BLUE;
                  end else begin
                     rsp.read_data = entry[7:0];
                     comp = COMP_RED;
                     pal_addr++;
                  end
               end
               REG_COMMAND: rsp.read_data = {3'b000, cmd_bits};
               REG_STATUS: begin
                  thr = cmd_bits[4] ? FIFO_DEPTH - 8 : FIFO_DEPTH / 2;
                  rsp.read_data = {3'b000, write_fifo_mirror.size() >= thr,
                                   write_fifo_mirror.size() >= FIFO_DEPTH,
                                   write_fifo_mirror.size() == 0, comp};
               end
               REG_COLOR_BUF: begin
                  if (comp == COMP_RED) begin
                     rsp.read_data = held_color[23:16];
                     comp = COMP_GREEN;
                  end else if (comp == COMP_GREEN) begin
                     rsp.read_data = held_color[15:8];
                     comp = COMP_BLUE;
                  end
               end
               REG_REVISION: rsp.read_data = {board_rev, 1'b0, chip_rev};
               default: rsp.read_data = '0;
            endcase
         end
         CMD_WRITE: begin
            case (r.reg_select)
               REG_ADDR_LO: begin
                  pal_addr[7:0] = r.write_data;
                  comp = COMP_RED;
               end
               REG_ADDR_HI: begin
                  pal_addr[12:8] = r.write_data[4:0];
                  comp = COMP_RED;
               end
               REG_PALETTE: begin
                  if (comp == COMP_RED) begin
                     palette_mirror[pal_addr][23:16] = r.write_data;
                     comp = COMP_GREEN;
                  end else if (comp == COMP_GREEN) begin
                     palette_mirror[pal_addr][15:8] = r.write_data;
                     comp = COMP_BLUE;
                  end else begin
                     palette_mirror[pal_addr][7:0] = r.write_data;
                     if (write_fifo_mirror.size() < FIFO_DEPTH)
                        write_fifo_mirror.push_back({pal_addr, palette_mirror[pal_addr]});
                     comp = COMP_RED;
                     pal_addr++;
                  end
               end
               REG_COMMAND: cmd_bits = r.write_data[4:0];
               default: ;
            endcase
         end
         CMD_PIXEL: begin
            if (r.pixel_mode == MODE_INDEX) begin
               rsp.pixel_color = palette_mirror[r.pixel_in[12:0]];
            end else begin
               bank = RGB_BANK_BASE + {3'b000, r.pixel_mode};
               rsp.pixel_color = {palette_mirror[{bank, r.pixel_in[23:16]}][7:0],
                                  palette_mirror[{bank, r.pixel_in[15:8]}][7:0],
                                  palette_mirror[{bank, r.pixel_in[7:0]}][7:0]};
            end
         end
         default: begin
            if (write_fifo_mirror.size() != 0) begin
               popped = write_fifo_mirror.pop_front();
               rsp.pop_valid = 1'b1;
               rsp.pop_index = popped.index;
               rsp.pop_color = popped.color;
            end
         end
      endcase
      return rsp;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.cmd        = 2'($urandom_range(3));
      r.reg_select = 3'($urandom_range(7));
      r.write_data = 8'($urandom_range(255));
      r.pixel_in   = 24'($urandom_range(24'hFFFFFF));
      r.pixel_mode = 2'($urandom_range(3));
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      return $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
   endfunction

   function automatic logic [12:0] pick_address();
      case ($urandom_range(3))
         0: return 13'($urandom);
         1: return {5'(RGB_BANK_BASE + 5'($urandom_range(1, 3))), pick_byte()};
         2: return {5'd0, pick_byte()};
         default: return {5'($urandom), 8'($urandom_range(15))};
      endcase
   endfunction

   task automatic check_field(string field, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (hold_off_cycles != 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (responses_due.size() == 0) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
               $display("%0t: response with none outstanding, expected nothing, actual %h",
                        $time, rsp_payload);
         end else begin
            want = responses_due.pop_front();
            check_field("read_data", 24'(want.read_data), 24'(rsp_payload.read_data));
            check_field("pixel_color", want.pixel_color, rsp_payload.pixel_color);
            check_field("pop_valid", 24'(want.pop_valid), 24'(rsp_payload.pop_valid));
            check_field("pop_index", 24'(want.pop_index), 24'(rsp_payload.pop_index));
            check_field("pop_color", want.pop_color, rsp_payload.pop_color);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
      responses_due.push_back(port_response(r));
      if (!(r.cmd == CMD_WRITE && r.reg_select >= REG_STATUS))
         requests_counted++;
   endtask

   task automatic issue_request(logic [1:0] op, logic [2:0] sel, logic [7:0] data);
      req_type r;
      r = random_request();
      r.cmd = op;
      r.reg_select = sel;
      r.write_data = data;
      send_request(r);
   endtask

   task automatic lookup_pixel(logic [23:0] pix, logic [1:0] mode);
      req_type r;
      r = random_request();
      r.cmd = CMD_PIXEL;
      r.pixel_in = pix;
      r.pixel_mode = mode;
      send_request(r);
   endtask

   task automatic set_address(logic [12:0] a);
      issue_request(CMD_WRITE, REG_ADDR_LO, a[7:0]);
      issue_request(CMD_WRITE, REG_ADDR_HI, {3'($urandom), a[12:8]});
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (responses_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_config(logic [3:0] board, logic [2:0] chip);
      csr_write_en <= 1'b1;
      csr_index <= CSR_BOARD_REV;
      csr_wdata <= board;
      @(posedge clock);
      csr_index <= CSR_CHIP_REV;
      csr_wdata <= {1'($urandom), chip};
      @(posedge clock);
      csr_write_en <= 1'b0;
      board_rev = board;
      chip_rev = chip;
   endtask

   task automatic test_register_file();
      for (int s = REG_ADDR_LO; s <= REG_READ_INIT; s++)
         issue_request(CMD_READ, 3'(s), 8'h00);
      issue_request(CMD_WRITE, REG_COMMAND, 8'hFF);
      issue_request(CMD_READ, REG_COMMAND, 8'h00);
      for (int s = REG_STATUS; s <= REG_READ_INIT; s++)
         issue_request(CMD_WRITE, 3'(s), 8'hFF);
   endtask

   task automatic test_palette_access();
      set_address(13'h1FFF);
      issue_request(CMD_WRITE, REG_PALETTE, 8'hFF);
      issue_request(CMD_WRITE, REG_PALETTE, 8'h00);
      issue_request(CMD_WRITE, REG_PALETTE, 8'hA5);
      set_address(13'h1FFF);
      repeat (3) issue_request(CMD_READ, REG_PALETTE, 8'h00);
      repeat (3) issue_request(CMD_READ, REG_COLOR_BUF, 8'h00);
   endtask

   task automatic test_pixel_lookup();
      lookup_pixel(24'hFFFFFF, MODE_INDEX);
      lookup_pixel(24'hFFFFFF, 2'd3);
      lookup_pixel(24'h000000, 2'd1);
      lookup_pixel(24'h5A5A5A, 2'd2);
   endtask

   task automatic test_write_fifo_pop();
      repeat (2) issue_request(CMD_POP, REG_ADDR_LO, 8'h00);
   endtask

   task automatic test_fifo_fill();
      set_address(pick_address());
      issue_request(CMD_WRITE, REG_COMMAND, {3'($urandom), 1'b1, 4'($urandom)});
      for (int i = 0; i < FIFO_DEPTH + 4; i++) begin
         repeat (3) issue_request(CMD_WRITE, REG_PALETTE, 8'($urandom));
         if (i % 4 == 3)
            issue_request(CMD_READ, REG_STATUS, 8'($urandom));
         if (i == FIFO_DEPTH / 2 + 4)
            issue_request(CMD_WRITE, REG_COMMAND, {3'($urandom), 1'b0, 4'($urandom)});
      end
      issue_request(CMD_READ, REG_STATUS, 8'($urandom));
      repeat (FIFO_DEPTH + 5) begin
         issue_request(CMD_POP, 3'($urandom), 8'($urandom));
         if ($urandom_range(7) == 0)
            issue_request(CMD_READ, REG_STATUS, 8'($urandom));
      end
   endtask

   task automatic test_random_traffic(int count, int pop_weight);
      int target;
      int choice;
      logic [1:0] mode;
      target = requests_counted + count;
      while (requests_counted < target) begin
         choice = $urandom_range(99);
         if (choice < 30) begin
            if ($urandom_range(3) != 0)
               set_address(pick_address());
            repeat (($urandom_range(9) == 0) ? $urandom_range(1, 5) : 3)
               issue_request(CMD_WRITE, REG_PALETTE, 8'($urandom));
         end else if (choice < 45) begin
            if ($urandom_range(2) != 0)
               set_address(pick_address());
            repeat (($urandom_range(9) == 0) ? $urandom_range(1, 5) : 3)
               issue_request(CMD_READ, REG_PALETTE, 8'($urandom));
            repeat ($urandom_range(3))
               issue_request(CMD_READ, REG_COLOR_BUF, 8'($urandom));
         end else if (choice < 65) begin
            mode = 2'($urandom_range(3));
            if (mode == MODE_INDEX)
               lookup_pixel({11'($urandom), pick_address()}, mode);
            else
               lookup_pixel({pick_byte(), pick_byte(), pick_byte()}, mode);
         end else if (choice < 65 + pop_weight) begin
            repeat ($urandom_range(1, 4))
               issue_request(CMD_POP, 3'($urandom), 8'($urandom));
         end else if (choice < 75 + pop_weight) begin
            if ($urandom_range(3) == 0)
               issue_request(CMD_WRITE, REG_COMMAND, 8'($urandom));
            else
               issue_request(CMD_READ, 3'($urandom_range(7)), 8'($urandom));
         end else begin
            send_request(random_request());
         end
      end
   endtask

   task automatic test_backpressure();
      hold_off_cycles <= 400;
      test_random_traffic(60, 15);
      wait_for_responses();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_config(4'hF, 3'h7);
      send_idle_pct = 10;
      recv_idle_pct <= 60;
      test_register_file();
      test_palette_access();
      test_pixel_lookup();
      test_write_fifo_pop();
      test_random_traffic(600, 5);
      wait_for_responses();

      write_config(4'h0, 3'h0);
      send_idle_pct = 60;
      recv_idle_pct <= 10;
      test_fifo_fill();
      test_random_traffic(550, 25);
      test_backpressure();

      write_config(4'h9, 3'h3);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      test_random_traffic(600, 15);
      wait_for_responses();

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
src/cpr_pkg.sv
src/cpr_wfifo.sv
src/color_palette_ramdac_port.sv
dv/color_palette_ramdac_port_test.sv
